/* rtl/core/slug_pkg.sv */
`default_nettype none

package slug_pkg;

    localparam int TABLE_ENTRIES_DEF = 32;
    // extra warm-up steps run before the table starts filling
    localparam int SEED_EXTRA = 8;

    localparam int STATE_W = 32;
    localparam int DRAW_W  = 31;
    localparam int MULT_W  = 15;
    localparam int PROD_W  = STATE_W + MULT_W;

    localparam logic [MULT_W-1:0] LEH_MULT    = 15'd16807;
    localparam logic [DRAW_W-1:0] CLAMP_LIMIT = 31'd2147483390;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_RED,
        ST_DRAW_MUL,
        ST_DRAW_RED,
        ST_DRAW_WR,
        ST_HOLD
    } slug_state_t;

endpackage

`default_nettype wire

/* rtl/core/slug_if.sv */
`default_nettype none

interface slug_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] new_seed;

    modport source (output valid, input ready, output kind, output new_seed);
    modport sink (input valid, output ready, input kind, input new_seed);
endinterface

interface slug_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] draw_value;
    logic        clamped;

    modport source (output valid, input ready, output draw_value, output clamped);
    modport sink (input valid, output ready, input draw_value, input clamped);
endinterface

`default_nettype wire

/* rtl/core/slug_step.sv */
`default_nettype none

module slug_step (
    input  wire logic                         clk,
    input  wire logic                         mul_en,
    input  wire logic [slug_pkg::STATE_W-1:0] operand,
    output logic      [slug_pkg::DRAW_W-1:0]  result
);
    import slug_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [STATE_W-1:0] fold_sum;
    logic [STATE_W-1:0] fold_inc;

    assign prod_next = PROD_W'(operand) * PROD_W'(LEH_MULT);

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    // 2^31 == 1 mod (2^31 - 1): fold the high part onto the low part
    assign fold_sum = STATE_W'(prod_reg[DRAW_W-1:0])
                    + STATE_W'(prod_reg[PROD_W-1:DRAW_W]);
    assign fold_inc = fold_sum + STATE_W'(1);

    // carry into bit 31 of sum+1 means sum >= modulus; drop one modulus
    assign result = fold_inc[DRAW_W] ? fold_inc[DRAW_W-1:0] : fold_sum[DRAW_W-1:0];

endmodule

`default_nettype wire

/* rtl/core/slug_index.sv */
`default_nettype none

module slug_index #(
    parameter int TABLE_ENTRIES = slug_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             calc_en,
    input  wire logic [slug_pkg::DRAW_W-1:0]      value,
    output logic      [$clog2(TABLE_ENTRIES)-1:0] idx
);
    import slug_pkg::*;

    localparam longint unsigned LehMod   = 64'd2147483647;
    localparam longint unsigned TwoPow31 = 64'd2147483648;
    localparam longint unsigned Divisor  = 64'd1 + (LehMod - 64'd1) / TABLE_ENTRIES;
    localparam longint unsigned Recip    = TwoPow31 / Divisor;
    localparam int QW  = $clog2(Recip + 1);
    localparam int IW  = $clog2(TABLE_ENTRIES);
    localparam int PW  = DRAW_W + QW;
    localparam int TW  = DRAW_W + 2;

    logic [QW-1:0]     qest_reg;
    logic [QW-1:0]     qest_next;
    logic [DRAW_W-1:0] val_reg;
    logic [PW-1:0]     recip_prod;
    logic [TW-1:0]     thr [2**QW];
    logic              above;
    logic [QW:0]       quot;
    logic [QW:0]       quot_wrap;

    // estimate is the true quotient or one below it
    assign recip_prod = PW'(value) * PW'(Recip);
    assign qest_next  = recip_prod[PW-1:DRAW_W];

    always_ff @(posedge clk)
    begin
        if (calc_en)
        begin
            qest_reg <= qest_next;
            val_reg  <= value;
        end
    end

    // boundary of the next quotient step, one constant per estimate
    for (genvar k = 0; k < 2**QW; k++)
    begin : g_thr
        assign thr[k] = TW'((k + 1) * Divisor);
    end

    assign above     = TW'(val_reg) >= thr[qest_reg];
    assign quot      = (QW+1)'(qest_reg) + (QW+1)'(above);
    assign quot_wrap = (quot >= (QW+1)'(TABLE_ENTRIES))
                     ? quot - (QW+1)'(TABLE_ENTRIES) : quot;
    assign idx       = quot_wrap[IW-1:0];

endmodule

`default_nettype wire

/* rtl/core/slug_table.sv */
`default_nettype none

module slug_table #(
    parameter int ENTRIES = slug_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(ENTRIES)-1:0]       wr_addr,
    input  wire logic [slug_pkg::DRAW_W-1:0]      wr_data,
    input  wire logic                             rd_en,
    input  wire logic [$clog2(ENTRIES)-1:0]       rd_addr,
    output logic      [slug_pkg::DRAW_W-1:0]      rd_data
);
    import slug_pkg::*;

    logic [DRAW_W-1:0] mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/shuffled_lehmer_uniform_generator_unit.sv */
`default_nettype none

// Minimal-standard Lehmer generator (x' = 16807 x mod 2^31-1) behind a shuffle
// table: each transfer on req yields one transfer on rsp. kind=1 loads new_seed
// before the draw. An ordinary draw passes through the draw multiply, reduce
// and write states before the next req transfer, and waits in a hold state
// while rsp is full; the shared multiply/reduce unit takes a multiply state and
// a reduce state per Lehmer step, and the table read is registered. When the
// state is not positive or the last draw was zero (always true after reset),
// the draw is preceded by seeding: TABLE_ENTRIES+8 Lehmer steps. req.ready is
// low while an item is in work; the result sits in an output register, so the
// next item may be taken before rsp is drained. Software forms the fraction as
// draw_value/(2^31-1); clamped flags draws at or above 2147483390.
module shuffled_lehmer_uniform_generator_unit #(
    parameter int TABLE_ENTRIES = slug_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    slug_in_if.sink      req,
    slug_out_if.source   rsp
);
    import slug_pkg::*;

    localparam int AW        = $clog2(TABLE_ENTRIES);
    localparam int SeedSteps = TABLE_ENTRIES + SEED_EXTRA;
    localparam int CW        = $clog2(SeedSteps);

    slug_state_t        state_reg;
    slug_state_t        state_next;
    logic [STATE_W-1:0] lehmer_reg;
    logic [STATE_W-1:0] lehmer_next;
    logic [DRAW_W-1:0]  last_reg;
    logic [DRAW_W-1:0]  last_next;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      cnt_next;
    logic [AW-1:0]      idx_reg;
    logic [AW-1:0]      idx_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [DRAW_W-1:0]  draw_reg;
    logic [DRAW_W-1:0]  draw_next;
    logic               clamp_reg;
    logic               clamp_next;

    logic               mul_en;
    logic               idx_en;
    logic [DRAW_W-1:0]  step_result;
    logic [AW-1:0]      draw_idx;
    logic               tbl_wr;
    logic [AW-1:0]      tbl_wr_addr;
    logic [DRAW_W-1:0]  tbl_wr_data;
    logic               tbl_rd;
    logic [DRAW_W-1:0]  tbl_rd_data;

    logic [STATE_W-1:0] eff_state;
    logic               need_seed;
    logic [STATE_W-1:0] seed_init;

    slug_step u_step (
        .clk     (clk),
        .mul_en  (mul_en),
        .operand (lehmer_reg),
        .result  (step_result)
    );

    slug_index #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_index (
        .clk     (clk),
        .calc_en (idx_en),
        .value   (last_reg),
        .idx     (draw_idx)
    );

    slug_table #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd),
        .rd_addr (draw_idx),
        .rd_data (tbl_rd_data)
    );

    assign eff_state = req.kind ? req.new_seed : lehmer_reg;
    assign need_seed = ($signed(eff_state) <= $signed(STATE_W'(0)))
                    || (last_reg == DRAW_W'(0));
    // most negative seed negates to 2^31, read as unsigned by the multiplier
    assign seed_init = ($signed(eff_state) >= $signed(STATE_W'(0)))
                     ? STATE_W'(1) : (~eff_state + STATE_W'(1));

    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.draw_value = draw_reg;
    assign rsp.clamped    = clamp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lehmer_reg    <= '0;
            last_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lehmer_reg    <= lehmer_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        draw_reg  <= draw_next;
        clamp_reg <= clamp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        lehmer_next    = lehmer_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        draw_next      = draw_reg;
        clamp_next     = clamp_reg;
        out_valid_next = out_valid_reg;
        mul_en         = 1'b0;
        idx_en         = 1'b0;
        tbl_wr         = 1'b0;
        tbl_wr_addr    = idx_reg;
        tbl_wr_data    = step_result;
        tbl_rd         = 1'b0;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (need_seed)
                    begin
                        lehmer_next = seed_init;
                        cnt_next    = CW'(SeedSteps - 1);
                        state_next  = ST_SEED_MUL;
                    end
                    else
                    begin
                        lehmer_next = eff_state;
                        state_next  = ST_DRAW_MUL;
                    end
                end
            end
            ST_SEED_MUL:
            begin
                mul_en     = 1'b1;
                state_next = ST_SEED_RED;
            end
            ST_SEED_RED:
            begin
                lehmer_next = {1'b0, step_result};
                // the last TABLE_ENTRIES steps fill the table, final one into entry 0
                if (cnt_reg < CW'(TABLE_ENTRIES))
                begin
                    tbl_wr      = 1'b1;
                    tbl_wr_addr = cnt_reg[AW-1:0];
                end
                if (cnt_reg == CW'(0))
                begin
                    last_next  = step_result;
                    state_next = ST_DRAW_MUL;
                end
                else
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = ST_SEED_MUL;
                end
            end
            ST_DRAW_MUL:
            begin
                mul_en     = 1'b1;
                idx_en     = 1'b1;
                state_next = ST_DRAW_RED;
            end
            ST_DRAW_RED:
            begin
                lehmer_next = {1'b0, step_result};
                tbl_rd      = 1'b1;
                idx_next    = draw_idx;
                state_next  = ST_DRAW_WR;
            end
            ST_DRAW_WR:
            begin
                // swap: emit the selected entry, put the new state in its place
                tbl_wr      = 1'b1;
                tbl_wr_addr = idx_reg;
                tbl_wr_data = lehmer_reg[DRAW_W-1:0];
                last_next   = tbl_rd_data;
                if (!out_valid_reg || rsp.ready)
                begin
                    draw_next      = tbl_rd_data;
                    clamp_next     = tbl_rd_data >= CLAMP_LIMIT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    draw_next      = last_reg;
                    clamp_next     = last_reg >= CLAMP_LIMIT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
